// File: rtl/jsu_pkg.sv
// types, constants and result helpers shared by the json string unescaper
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package jsu_pkg;

	// decoder phase, one-hot
	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_STR  = 7'b0000010,
		PH_ESC  = 7'b0000100,
		PH_HEX1 = 7'b0001000,
		PH_BSL  = 7'b0010000,
		PH_U    = 7'b0100000,
		PH_HEX2 = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NO_QUOTE    = 4'd0,
		ERR_CTRL_CHAR   = 4'd1,
		ERR_OPEN_ESC    = 4'd2,
		ERR_BAD_ESC     = 4'd3,
		ERR_SHORT_HEX   = 4'd4,
		ERR_BAD_HEX     = 4'd5,
		ERR_LONE_HIGH   = 4'd6,
		ERR_BAD_LOW     = 4'd7,
		ERR_LONE_LOW    = 4'd8,
		ERR_OPEN_STRING = 4'd9
	} err_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// top six bits of a high and a low surrogate
	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [5:0] SURR_LOW  = 6'b110111;
	// 0x10000 >> 10, added to the high surrogate bits
	localparam logic [10:0] PLANE_BASE = 11'h040;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  hex_cnt;
		logic [15:0] hex_acc;
		logic [9:0]  hi_bits;
		logic        bad_hex;
	} jsu_st_t;

	localparam jsu_st_t ST_IDLE = '{PH_IDLE, 2'd0, 16'd0, 10'd0, 1'b0};

	// all results caused by one input item, bytes[0] goes out first
	typedef struct packed {
		logic [2:0]       cnt;
		kind_t            kind;
		err_t             err;
		logic [3:0][7:0]  bytes;
	} jsu_res_t;

	function automatic jsu_res_t res_err(err_t e);
		jsu_res_t r;
		r       = '0;
		r.cnt   = 3'd1;
		r.kind  = KIND_ERR;
		r.err   = e;
		return r;
	endfunction

	function automatic jsu_res_t res_byte(logic [7:0] b);
		jsu_res_t r;
		r          = '0;
		r.cnt      = 3'd1;
		r.kind     = KIND_BYTE;
		r.bytes[0] = b;
		return r;
	endfunction

	function automatic jsu_res_t res_done();
		jsu_res_t r;
		r      = '0;
		r.cnt  = 3'd1;
		r.kind = KIND_DONE;
		return r;
	endfunction

endpackage

// File: rtl/jsu_utf8.sv
// utf-8 encoder: code point to one to four bytes
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_utf8 (
	input  logic [20:0]      cp,
	output logic [2:0]       cnt,
	output logic [3:0][7:0]  bytes
);
	import jsu_pkg::*;

	always_comb begin
		bytes = '0;
		if (cp[20:7] == 14'd0) begin
			cnt      = 3'd1;
			bytes[0] = {1'b0, cp[6:0]};
		end else if (cp[20:11] == 10'd0) begin
			cnt      = 3'd2;
			bytes[0] = {3'b110, cp[10:6]};
			bytes[1] = {2'b10, cp[5:0]};
		end else if (cp[20:16] == 5'd0) begin
			cnt      = 3'd3;
			bytes[0] = {4'b1110, cp[15:12]};
			bytes[1] = {2'b10, cp[11:6]};
			bytes[2] = {2'b10, cp[5:0]};
		end else begin
			cnt      = 3'd4;
			bytes[0] = {5'b11110, cp[20:18]};
			bytes[1] = {2'b10, cp[17:12]};
			bytes[2] = {2'b10, cp[11:6]};
			bytes[3] = {2'b10, cp[5:0]};
		end
	end

endmodule

// File: rtl/jsu_decode.sv
// next-state and result logic for one input byte or end marker
// depends on jsu_pkg and jsu_utf8
`timescale 1ns / 1ps

module jsu_decode (
	input  jsu_pkg::jsu_st_t  cur,
	input  logic              mode,
	input  logic [7:0]        data_byte,
	output jsu_pkg::jsu_st_t  nxt,
	output jsu_pkg::jsu_res_t res
);
	import jsu_pkg::*;

	logic [3:0]       hex_val;
	logic             hex_bad;
	logic [15:0]      acc_new;
	logic             bad_new;
	logic             hex_full;
	logic             is_ws;
	logic [10:0]      plane;
	logic [20:0]      cp;
	logic [2:0]       enc_cnt;
	logic [3:0][7:0]  enc_bytes;
	jsu_res_t         res_cp;

	always_comb begin
		hex_val = 4'd0;
		hex_bad = 1'b0;
		if (data_byte inside {[8'h30:8'h39]}) begin
			hex_val = 4'(data_byte - 8'h30);
		end else if (data_byte inside {[8'h61:8'h66]}) begin
			hex_val = 4'(data_byte - 8'h57);
		end else if (data_byte inside {[8'h41:8'h46]}) begin
			hex_val = 4'(data_byte - 8'h37);
		end else begin
			hex_bad = 1'b1;
		end
	end

	assign acc_new  = {cur.hex_acc[11:0], hex_val};
	assign bad_new  = cur.bad_hex | hex_bad;
	assign hex_full = (cur.hex_cnt == 2'd3);
	assign is_ws    = (data_byte == CH_SPACE) || (data_byte inside {[8'h09:8'h0D]});

	// surrogate pair joins as ((high + 0x40) << 10) | low
	assign plane = {1'b0, cur.hi_bits} + PLANE_BASE;
	assign cp    = (cur.phase == PH_HEX2) ? {plane, acc_new[9:0]} : {5'd0, acc_new};

	jsu_utf8 u_utf8 (
		.cp    (cp),
		.cnt   (enc_cnt),
		.bytes (enc_bytes)
	);

	always_comb begin
		res_cp       = '0;
		res_cp.cnt   = enc_cnt;
		res_cp.kind  = KIND_BYTE;
		res_cp.bytes = enc_bytes;
	end

	always_comb begin
		nxt = cur;
		res = '0;
		if (mode) begin
			nxt = ST_IDLE;
			case (cur.phase)
				PH_IDLE: res = res_err(ERR_NO_QUOTE);
				PH_STR:  res = res_err(ERR_OPEN_STRING);
				PH_ESC:  res = res_err(ERR_OPEN_ESC);
				PH_HEX1: res = res_err(ERR_SHORT_HEX);
				PH_HEX2: res = res_err(ERR_SHORT_HEX);
				default: res = res_err(ERR_LONE_HIGH);
			endcase
		end else begin
			case (cur.phase)
				PH_IDLE: begin
					if (data_byte == CH_QUOTE) begin
						nxt.phase = PH_STR;
					end else if (!is_ws) begin
						nxt = ST_IDLE;
						res = res_err(ERR_NO_QUOTE);
					end
				end
				PH_STR: begin
					if (data_byte == CH_QUOTE) begin
						nxt = ST_IDLE;
						res = res_done();
					end else if (data_byte < CH_SPACE) begin
						nxt = ST_IDLE;
						res = res_err(ERR_CTRL_CHAR);
					end else if (data_byte == CH_BSL) begin
						nxt.phase = PH_ESC;
					end else begin
						res = res_byte(data_byte);
					end
				end
				PH_ESC: begin
					nxt.phase = PH_STR;
					case (data_byte)
						CH_QUOTE, CH_BSL, CH_SLASH: res = res_byte(data_byte);
						CH_B: res = res_byte(8'h08);
						CH_F: res = res_byte(8'h0C);
						CH_N: res = res_byte(8'h0A);
						CH_R: res = res_byte(8'h0D);
						CH_T: res = res_byte(8'h09);
						CH_U: begin
							nxt.phase   = PH_HEX1;
							nxt.hex_cnt = 2'd0;
							nxt.hex_acc = 16'd0;
							nxt.bad_hex = 1'b0;
						end
						default: begin
							nxt = ST_IDLE;
							res = res_err(ERR_BAD_ESC);
						end
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					nxt.hex_acc = acc_new;
					nxt.bad_hex = bad_new;
					nxt.hex_cnt = cur.hex_cnt + 2'd1;
					if (hex_full) begin
						if (bad_new) begin
							nxt = ST_IDLE;
							res = res_err(ERR_BAD_HEX);
						end else if (cur.phase == PH_HEX1) begin
							if (acc_new[15:10] == SURR_HIGH) begin
								nxt.hi_bits = acc_new[9:0];
								nxt.phase   = PH_BSL;
							end else if (acc_new[15:10] == SURR_LOW) begin
								nxt = ST_IDLE;
								res = res_err(ERR_LONE_LOW);
							end else begin
								nxt.phase = PH_STR;
								res       = res_cp;
							end
						end else begin
							if (acc_new[15:10] != SURR_LOW) begin
								nxt = ST_IDLE;
								res = res_err(ERR_BAD_LOW);
							end else begin
								nxt.phase   = PH_STR;
								nxt.hi_bits = 10'd0;
								res         = res_cp;
							end
						end
					end
				end
				PH_BSL: begin
					if (data_byte == CH_BSL) begin
						nxt.phase = PH_U;
					end else begin
						nxt = ST_IDLE;
						res = res_err(ERR_LONE_HIGH);
					end
				end
				PH_U: begin
					if (data_byte == CH_U) begin
						nxt.phase   = PH_HEX2;
						nxt.hex_cnt = 2'd0;
						nxt.hex_acc = 16'd0;
						nxt.bad_hex = 1'b0;
					end else begin
						nxt = ST_IDLE;
						res = res_err(ERR_LONE_HIGH);
					end
				end
				default: nxt = ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/jsu_out_buf.sv
// result register: holds the results of one item and sends them one per transfer
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  jsu_pkg::jsu_res_t  res,
	output logic               free,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);
	import jsu_pkg::*;

	logic      vld_q;
	logic [1:0] idx_q;
	jsu_res_t  res_q;
	logic      pop;
	logic      last_ent;

	assign pop      = vld_q && m_tready;
	assign last_ent = ({1'b0, idx_q} == (res_q.cnt - 3'd1));
	assign free     = !vld_q || (pop && last_ent);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (pop) begin
			if (last_ent) begin
				vld_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {4'd0, res_q.err, res_q.bytes[idx_q]};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = last_ent;

endmodule

// File: rtl/json_string_unescape_utf8.sv
// top level of the json string unescaper with utf-8 output
// depends on jsu_pkg, jsu_decode, jsu_utf8 and jsu_out_buf
`timescale 1ns / 1ps

// channel  | signals                         | contents
// ---------+---------------------------------+----------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser | s_tdata[7:0] data_byte, s_tuser[0] mode
// result   | m_tvalid m_tready m_tdata m_tuser | m_tdata[7:0] out_byte, [11:8] error_code,
//          | m_tlast                         | m_tuser[1:0] kind, m_tlast last
//
// an item is taken into the input register, decoded combinationally against the
// phase registers and its results land in the result register
// one item per cycle for items that give zero or one result while m_tready holds;
// an escape that encodes to n utf-8 bytes holds the decoder until the result
// register has drained all n bytes, one byte per transfer
// arst_n clears the phase registers and both valid flags; the block then waits
// for an opening quote
// a stall on the result side fills the input register, then drops s_tready

module json_string_unescape_utf8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);
	import jsu_pkg::*;

	// input register
	logic       vld_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;

	// decoder state
	jsu_st_t  st_q;
	jsu_st_t  st_nxt;
	jsu_res_t res;

	logic buf_free;
	logic fire;
	logic load;

	// decode the held item once the result register can take its results
	assign fire     = vld_s1 && buf_free;
	assign load     = fire && (res.cnt != 3'd0);
	assign s_tready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	jsu_decode u_decode (
		.cur       (st_q),
		.mode      (mode_s1),
		.data_byte (byte_s1),
		.nxt       (st_nxt),
		.res       (res)
	);

	jsu_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.free     (buf_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	// done and error results always stand alone
	a_single_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_BYTE) |-> m_tlast)
		else $error("status result not marked last");

	// an error sends the decoder back to waiting for a quote
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.cnt != 3'd0) && (res.kind == KIND_ERR) |=> st_q.phase == PH_IDLE)
		else $error("decoder not idle after error");

	// only utf-8 sequences produce several results
	a_multi_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.cnt > 3'd1) |-> res.kind == KIND_BYTE)
		else $error("multi-result item is not a byte sequence");
`endif

endmodule
